[design/pll_pkg.sv]
// ----------------------------------------------------------------------------
// pll_pkg
// shared types and constants for the positional list engine
// ----------------------------------------------------------------------------
package pll_pkg;

    // fixed field widths of the command and result items
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // defaults for the top level parameters
    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_GET        = 3'd5,
        CMD_REMOVE     = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // what every cell of the chain does
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_OPEN  = 2'd1,
        CELL_CLOSE = 2'd2
    } t_cell_op;

endpackage

[design/pll_if.sv]
// ----------------------------------------------------------------------------
// pll_in_if / pll_out_if
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface pll_in_if;
    logic                      valid;
    logic                      ready;
    logic [pll_pkg::CMD_W-1:0]  cmd;
    logic [pll_pkg::POS_W-1:0]  pos;
    logic [pll_pkg::ITEM_W-1:0] item;

    modport source (output valid, cmd, pos, item, input ready);
    modport sink   (input valid, cmd, pos, item, output ready);
endinterface

interface pll_out_if;
    logic                        valid;
    logic                        ready;
    logic [pll_pkg::STATUS_W-1:0] status;
    logic [pll_pkg::ITEM_W-1:0]   data_out;
    logic [pll_pkg::LEN_W-1:0]    length;
    logic                        is_empty;

    modport source (output valid, status, data_out, length, is_empty, input ready);
    modport sink   (input valid, status, data_out, length, is_empty, output ready);
endinterface

[design/pll_cell.sv]
// ----------------------------------------------------------------------------
// pll_cell
// one list slot: holds a word, shifts from a neighbor or loads a new word
// ----------------------------------------------------------------------------
module pll_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
) (
    input  logic                   i_clk,
    input  pll_pkg::t_cell_op      i_op,
    input  logic [IDX_W-1:0]       i_target,
    input  logic [DATA_WIDTH-1:0]  i_prev,
    input  logic [DATA_WIDTH-1:0]  i_next,
    input  logic [DATA_WIDTH-1:0]  i_load,
    output logic [DATA_WIDTH-1:0]  o_word
);
    import pll_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_op)
            CELL_OPEN: begin
                // slots behind the gap move back, the gap takes the new word
                if (MY_IDX > i_target) begin
                    n_word = i_prev;
                end else if (MY_IDX == i_target) begin
                    n_word = i_load;
                end
            end
            CELL_CLOSE: begin
                // slots from the gap on pull the word behind them forward
                if (MY_IDX >= i_target) begin
                    n_word = i_next;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

[design/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_engine
// bounded ordered list with push/pop at both ends and positional access
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after its command item is taken
// throughput: one command per cycle while the result side takes its items; every cell of the chain shifts in parallel
//   and the decode of count/position plus the read select set the cycle time
// reset: clears the entry count and the result valid flag and holds ready low;
//   the cells are not cleared, slots at or beyond the count are never read
module positional_list_engine #(
    parameter int DEPTH      = pll_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = pll_pkg::DEF_DATA_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pll_in_if.sink    i_in,
    pll_out_if.source o_out
);
    import pll_pkg::*;

    // count must hold DEPTH itself, cell index only DEPTH-1
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // list state
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;

    // result register
    logic                   r_out_valid;
    t_status                r_status;
    t_status                n_status;
    logic [ITEM_W-1:0]      r_data;
    logic [ITEM_W-1:0]      n_data;
    logic [LEN_W-1:0]       r_length;
    logic                   r_empty;

    // command decode
    logic                   accept;
    logic                   full;
    logic                   empty;
    logic [CMP_W-1:0]       pos_x;
    logic [CMP_W-1:0]       cnt_x;
    t_cell_op               op;
    t_cell_op               cell_op;
    logic [CMP_W-1:0]       target_x;
    logic [IDX_W-1:0]       target;
    logic                   rd_en;
    logic [CMP_W-1:0]       rd_x;
    logic [IDX_W-1:0]       rd_idx;
    logic [DATA_WIDTH-1:0]  load_word;
    logic [DATA_WIDTH-1:0]  words [DEPTH];

    // the result register parts the two sides: a new item may enter while
    // the current result is being taken; nothing is taken during reset
    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);
    assign pos_x = CMP_W'(i_in.pos);
    assign cnt_x = CMP_W'(r_count);

    // one decision per command: what the chain does, where, and what is read
    always_comb begin
        op       = CELL_HOLD;
        target_x = '0;
        rd_en    = 1'b0;
        rd_x     = '0;
        n_status = ST_OK;
        n_count  = r_count;
        unique case (i_in.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    op       = CELL_OPEN;
                    // push back opens the gap just past the last entry
                    target_x = (i_in.cmd == CMD_PUSH_BACK) ? cnt_x : '0;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_RANGE;
                end else begin
                    op       = CELL_CLOSE;
                    target_x = (i_in.cmd == CMD_POP_BACK) ? (cnt_x - CMP_W'(1)) : '0;
                    rd_en    = 1'b1;
                    rd_x     = target_x;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            CMD_INSERT: begin
                // range check wins over the full check
                if (pos_x > cnt_x) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    op       = CELL_OPEN;
                    target_x = pos_x;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            CMD_GET: begin
                if (pos_x >= cnt_x) begin
                    n_status = ST_RANGE;
                end else begin
                    rd_en = 1'b1;
                    rd_x  = pos_x;
                end
            end
            CMD_REMOVE: begin
                if (pos_x >= cnt_x) begin
                    n_status = ST_RANGE;
                end else begin
                    op       = CELL_CLOSE;
                    target_x = pos_x;
                    rd_en    = 1'b1;
                    rd_x     = pos_x;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                // unused command code: no change
                n_status = ST_RANGE;
            end
        endcase
    end

    // targets are below DEPTH whenever the chain acts, so truncation is safe
    assign target    = IDX_W'(target_x);
    assign rd_idx    = IDX_W'(rd_x);
    assign cell_op   = accept ? op : CELL_HOLD;
    assign load_word = DATA_WIDTH'(i_in.item);

    // read select happens before the chain moves, so it sees the old order
    assign n_data = rd_en ? ITEM_W'(words[rd_idx]) : '0;

    // chain of cells; the ends see a dummy front neighbor and hold at the back
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_word;
        logic [DATA_WIDTH-1:0] next_word;

        if (g == 0) begin : g_front
            assign prev_word = '0;
        end else begin : g_mid_prev
            assign prev_word = words[g-1];
        end

        if (g == DEPTH - 1) begin : g_back
            assign next_word = words[g];
        end else begin : g_mid_next
            assign next_word = words[g+1];
        end

        pll_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_op     (cell_op),
            .i_target (target),
            .i_prev   (prev_word),
            .i_next   (next_word),
            .i_load   (load_word),
            .o_word   (words[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with every accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_length <= LEN_W'(n_count);
            r_empty  <= (n_count == '0);
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_status;
    assign o_out.data_out = r_data;
    assign o_out.length   = r_length;
    assign o_out.is_empty = r_empty;

    // count never runs past the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // the list changes only when an item is taken
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("entry count moved without an item");

    // a pending result agrees with the live count
    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_empty == (r_count == '0)))
        else $error("empty flag out of step with count");

    // a push on a full list reports full and leaves the count alone
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && full && (i_in.cmd == CMD_PUSH_FRONT || i_in.cmd == CMD_PUSH_BACK))
        |=> (r_status == ST_FULL) && $stable(r_count))
        else $error("push on full list not refused");

endmodule

[verif/pll_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pll_tb_pkg
// shadow list and result checker for the positional list engine bench
// ----------------------------------------------------------------------------
package pll_tb_pkg;
    import pll_pkg::*;

    // command code the block does not define
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        t_status            status;
        logic [ITEM_W-1:0]  data_out;
        logic [LEN_W-1:0]   length;
        logic               is_empty;
    } list_result_t;

    class list_checker;
        logic [ITEM_W-1:0] slots [DEF_DEPTH];
        int unsigned       fill;
        int unsigned       mismatches;
        list_result_t      expected_results[$];

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // shift entries at and after p one place back, store w at p
        function void open_gap(int unsigned p, logic [ITEM_W-1:0] w);
            int unsigned i;
            for (i = fill; i > p; i--) slots[i] = slots[i-1];
            slots[p] = w;
            fill++;
        endfunction

        // take the entry at p out and pull later entries forward
        function logic [ITEM_W-1:0] close_gap(int unsigned p);
            logic [ITEM_W-1:0] w;
            int unsigned       i;
            w = slots[p];
            for (i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
            return w;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [ITEM_W-1:0] item);
            list_result_t r;
            bit           full;
            r.status   = ST_OK;
            r.data_out = '0;
            full = (fill >= DEF_DEPTH);
            case (cmd)
                CMD_PUSH_FRONT: begin
                    if (full) r.status = ST_FULL;
                    else open_gap(0, item);
                end
                CMD_PUSH_BACK: begin
                    if (full) r.status = ST_FULL;
                    else open_gap(fill, item);
                end
                CMD_POP_FRONT: begin
                    if (fill == 0) r.status = ST_RANGE;
                    else r.data_out = close_gap(0);
                end
                CMD_POP_BACK: begin
                    if (fill == 0) r.status = ST_RANGE;
                    else r.data_out = close_gap(fill - 1);
                end
                CMD_INSERT: begin
                    // range check wins over the full check
                    if (pos > fill) r.status = ST_RANGE;
                    else if (full) r.status = ST_FULL;
                    else open_gap(pos, item);
                end
                CMD_GET: begin
                    if (pos >= fill) r.status = ST_RANGE;
                    else r.data_out = slots[pos];
                end
                CMD_REMOVE: begin
                    if (pos >= fill) r.status = ST_RANGE;
                    else r.data_out = close_gap(pos);
                end
                default: r.status = ST_RANGE;
            endcase
            r.length   = LEN_W'(fill);
            r.is_empty = (fill == 0);
            expected_results.push_back(r);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [ITEM_W-1:0] data_out,
                                   logic [LEN_W-1:0] length, logic is_empty);
            list_result_t e;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result st=%0d data=%h len=%0d empty=%b",
                                 status, data_out, length, is_empty));
                return;
            end
            e = expected_results.pop_front();
            if (status !== e.status || data_out !== e.data_out ||
                length !== e.length || is_empty !== e.is_empty)
                report($sformatf("exp st=%0d data=%h len=%0d empty=%b, got st=%0d data=%h len=%0d empty=%b",
                                 e.status, e.data_out, e.length, e.is_empty,
                                 status, data_out, length, is_empty));
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void close_out();
            if (expected_results.size() != 0)
                report($sformatf("%0d results never arrived", expected_results.size()));
        endfunction
    endclass

endpackage

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives command items into the positional list engine with random gaps and
// back-pressure, keeps a shadow copy of the list and checks every result item
// ----------------------------------------------------------------------------
module tb_top;
    import pll_pkg::*;
    import pll_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1350;
    localparam int unsigned LIMIT_CYCLES = 300000;
    localparam int unsigned TAIL_CYCLES  = 4;

    logic i_clk;
    logic i_rst_n;

    pll_in_if  cmd_ch ();
    pll_out_if res_ch ();

    positional_list_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    // two-state counters and burst flags start at zero
    list_checker list_sb;
    int unsigned cycle_count;
    bit          sender_burst;
    bit          sink_burst;

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // wait length for one item; now and then flip into or out of a burst
    // so that long stretches run with no idling at all
    function automatic int unsigned draw_wait(inout bit burst);
        if ($urandom_range(0, 31) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    // one command item: optional idle gap, then hold valid until taken
    task automatic send_command(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                                logic [ITEM_W-1:0] w);
        int unsigned gap;
        gap = draw_wait(sender_burst);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd   <= c;
        cmd_ch.pos   <= p;
        cmd_ch.item  <= w;
        do @(posedge i_clk); while (!cmd_ch.ready);
        // accepted at this edge, the shadow list moves now
        list_sb.note_command(c, p, w);
        @(negedge i_clk);
    endtask

    // hold the sender off until every result is back
    task automatic drain_pause();
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (list_sb.pending() != 0) @(negedge i_clk);
    endtask

    // empty list cases, fill to the top with all-ones, all-zero and random words, full list cases
    task automatic run_directed();
        int unsigned k;
        send_command(CMD_POP_FRONT, 5'd0, '0);
        send_command(CMD_POP_BACK,  5'd0, '0);
        send_command(CMD_GET,       5'd0, '0);
        send_command(CMD_REMOVE,    5'd0, '0);
        send_command(CMD_INSERT,    5'd1, 32'h1234_5678);   // beyond length
        send_command(CMD_INSERT,    5'd0, 32'hA5A5_A5A5);   // pos equals length
        for (k = 0; k < DEF_DEPTH - 1; k++) begin
            case (k % 3)
                0: send_command(CMD_PUSH_FRONT, 5'd0, '1);
                1: send_command(CMD_PUSH_BACK, 5'd0, '0);
                default: send_command(CMD_INSERT, POS_W'(list_sb.fill / 2), $urandom);
            endcase
        end
        // list is full here
        send_command(CMD_PUSH_FRONT, 5'd0, 32'hDEAD_BEEF);
        send_command(CMD_PUSH_BACK,  5'd0, 32'hDEAD_BEEF);
        send_command(CMD_INSERT,     5'd16, 32'hDEAD_BEEF);   // valid pos but full
        send_command(CMD_REMOVE,     5'd16, '0);              // pos at length
        send_command(CMD_GET,        5'd15, '0);
        send_command(CMD_REMOVE,     5'd0, '0);
        send_command(CMD_UNUSED,     5'd31, '1);
    endtask

    // random commands; the add/remove mix drifts so the list swings between
    // empty and full and spends time in between
    task automatic run_random(int unsigned n_items);
        int unsigned      i;
        int unsigned      roll;
        int unsigned      add_pct;
        logic [CMD_W-1:0] c;
        logic [POS_W-1:0] p;
        logic [ITEM_W-1:0] w;
        add_pct = 45;
        for (i = 0; i < n_items; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: add_pct = 65;
                    1: add_pct = 25;
                    default: add_pct = 45;
                endcase
            end
            if (i % 400 == 200) drain_pause();

            roll = $urandom_range(0, 99);
            if (roll == 99)
                c = CMD_UNUSED;
            else if (roll < add_pct) begin
                case ($urandom_range(0, 2))
                    0: c = CMD_PUSH_FRONT;
                    1: c = CMD_PUSH_BACK;
                    default: c = CMD_INSERT;
                endcase
            end else if (roll < add_pct + 20)
                c = CMD_GET;
            else begin
                case ($urandom_range(0, 2))
                    0: c = CMD_POP_FRONT;
                    1: c = CMD_POP_BACK;
                    default: c = CMD_REMOVE;
                endcase
            end

            // mostly legal positions, some anywhere from 0 to 16
            p = POS_W'($urandom_range(0, 16));
            if ($urandom_range(0, 99) < 85) begin
                if (c == CMD_INSERT)
                    p = POS_W'($urandom_range(0, list_sb.fill));
                else if ((c == CMD_GET || c == CMD_REMOVE) && list_sb.fill > 0)
                    p = POS_W'($urandom_range(0, list_sb.fill - 1));
            end

            case ($urandom_range(0, 9))
                0: w = '0;
                1: w = '1;
                default: w = $urandom;
            endcase
            send_command(c, p, w);
        end
    endtask

    // result side: random stalls, check every item taken
    initial begin
        res_ch.ready <= 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            int unsigned stall;
            stall = draw_wait(sink_burst);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            list_sb.check_result(res_ch.status, res_ch.data_out, res_ch.length,
                                 res_ch.is_empty);
            @(negedge i_clk);
        end
    end

    // stimulus and end of run
    initial begin
        list_sb      = new();
        i_rst_n      = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd   = '0;
        cmd_ch.pos   = '0;
        cmd_ch.item  = '0;

        // synchronous reset held, then released off the edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        run_random(RANDOM_ITEMS);
        cmd_ch.valid <= 1'b0;

        // let the last results drain and the bench run quiet before the final check
        while (list_sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        list_sb.close_out();

        if (list_sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
